// ===== src/gssp_pkg.sv =====
package gssp_pkg;

  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned VID_BITS = 6;
  localparam int unsigned WIN_BITS = 16;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned WOUT_BITS = 16;
  localparam int unsigned DIST_BITS = 22;
  localparam int unsigned COUNT_BITS = 7;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_PATH   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK          = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_NO_EDGE     = 3'd2,
    ST_UNREACHABLE = 3'd3,
    ST_BAD_VERTEX  = 3'd4
  } status_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [VID_BITS-1:0]    vertex_a;
    logic [VID_BITS-1:0]    vertex_b;
    logic [WIN_BITS-1:0]    edge_weight_in;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [WOUT_BITS-1:0]   weight_out;
    logic [DIST_BITS-1:0]   distance;
  } rsp_t;

endpackage

// ===== src/gssp_if.sv =====
interface gssp_cmd_if;
  logic              valid;
  logic              ready;
  gssp_pkg::cmd_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gssp_rsp_if;
  logic              valid;
  logic              ready;
  gssp_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/gssp_adj_mem.sv =====
// Adjacency matrix: weight and valid bit per entry, one port of each kind.
// Valid bits are cleared by a sweep after reset.
module gssp_adj_mem #(
  parameter int unsigned ADDR_BITS = 12,
  parameter int unsigned DATA_BITS = 17
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);
  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/gssp_dist_mem.sv =====
// Working store of a path query: tentative distance, reached and settled marks.
module gssp_dist_mem #(
  parameter int unsigned ADDR_BITS = 6,
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);
  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/graph_store_shortest_path.sv =====
// Insert, weight query and rejected beats: from the accepted beat through S_CHECK, then S_RDWAIT
// and S_INS as needed, to S_OUT. Path query with n vertices: the working marks are rewritten,
// then per settled vertex a minimum scan and a row scan over the n entries follow; both scans
// use the single read port of a memory, one entry a cycle. One item is in work at a time.
// After reset the adjacency valid bits are cleared by a sweep over every entry, during which
// no beat is accepted; vertex_count resets to 0.
module graph_store_shortest_path #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  gssp_cmd_if.sink                         in_ch,
  gssp_rsp_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [gssp_pkg::COUNT_BITS-1:0]  cfg_wdata
);
  localparam int unsigned VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AB = 2 * VB;
  localparam int unsigned CB = VB + 1;
  localparam int unsigned DB = gssp_pkg::DIST_BITS;
  localparam int unsigned AW = WEIGHT_BITS + 1;
  localparam int unsigned DW = DB + 2;
  localparam int unsigned SB = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_CHECK  = 12'b000000000100,
    S_RDWAIT = 12'b000000001000,
    S_INS    = 12'b000000010000,
    S_INIT   = 12'b000000100000,
    S_SCAN   = 12'b000001000000,
    S_PICK   = 12'b000010000000,
    S_RELAX  = 12'b000100000000,
    S_FINAL  = 12'b001000000000,
    S_FINRD  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;
  logic [gssp_pkg::COUNT_BITS-1:0] vertex_count;
  gssp_pkg::cmd_t cmd;
  logic [CB-1:0] n_eff;
  logic [VB-1:0] va, vb;
  logic [AB-1:0] clr_addr;
  logic [CB-1:0] idx;
  logic          pend;
  logic [VB-1:0] pend_v;
  logic          found;
  logic [VB-1:0] best_u;
  logic [DB-1:0] best_d;
  logic [DB-1:0] u_d;
  logic [VB-1:0] u_v;
  logic          ins_second;
  logic          out_valid;
  gssp_pkg::rsp_t out_data;

  // The reached and settled marks are compared against an epoch bit that flips per path
  // query; the marks of the vertices in use are rewritten at the start of every query.
  logic          epoch;

  logic          adj_we;
  logic [AB-1:0] adj_waddr, adj_raddr;
  logic [AW-1:0] adj_wdata, adj_rdata;
  logic          dm_we;
  logic [VB-1:0] dm_waddr, dm_raddr;
  logic [DW-1:0] dm_wdata, dm_rdata;

  // Relax pipeline: row entry read, distance entry alongside.
  logic          rl_vld;
  logic [VB-1:0] rl_v;
  logic          fw_vld;
  logic [VB-1:0] fw_v;
  logic [DW-1:0] fw_data;

  logic [SB-1:0]  sum;
  logic [DB-1:0]  cand;
  logic [DW-1:0]  dm_eff;
  logic           d_reached, d_settled;

  gssp_adj_mem #(.ADDR_BITS(AB), .DATA_BITS(AW)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  gssp_dist_mem #(.ADDR_BITS(VB), .DATA_BITS(DW)) u_dist (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = CB'(MAX_VERTICES);
    end else begin
      n_eff = CB'(vertex_count);
    end
  end

  assign va = VB'(cmd.vertex_a);
  assign vb = VB'(cmd.vertex_b);

  // Distance entry layout: {epoch-tagged reached, epoch-tagged settled, distance}.
  always_comb begin
    dm_eff = dm_rdata;
    if (fw_vld && fw_v == rl_v) begin
      dm_eff = fw_data;
    end
  end
  assign d_reached = dm_eff[DW-1] == epoch;
  assign d_settled = dm_eff[DW-2] == epoch;

  assign sum  = SB'(u_d) + SB'(adj_rdata[WEIGHT_BITS-1:0]);
  assign cand = (sum > SB'(gssp_pkg::DIST_MAX)) ? gssp_pkg::DIST_MAX : sum[DB-1:0];

  always_comb begin
    adj_raddr = {va, vb};
    dm_raddr  = idx[VB-1:0];
    if (state == S_RELAX) begin
      adj_raddr = {u_v, idx[VB-1:0]};
    end else if (state == S_FINAL) begin
      dm_raddr = vb;
    end
  end

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = clr_addr;
    adj_wdata = '0;
    dm_we     = 1'b0;
    dm_waddr  = rl_v;
    dm_wdata  = '0;
    case (state)
      S_CLEAR: begin
        adj_we = 1'b1;
      end
      S_INS: begin
        adj_we    = 1'b1;
        adj_waddr = ins_second ? {vb, va} : {va, vb};
        adj_wdata = {1'b1, WEIGHT_BITS'(cmd.edge_weight_in)};
      end
      S_INIT: begin
        dm_we    = 1'b1;
        dm_waddr = idx[VB-1:0];
        dm_wdata = {(idx[VB-1:0] == va) ? epoch : ~epoch, ~epoch, {DB{1'b0}}};
      end
      S_PICK: begin
        dm_we    = 1'b1;
        dm_waddr = best_u;
        dm_wdata = {epoch, epoch, best_d};
      end
      S_RELAX, S_FINAL: begin
        if (rl_vld && adj_rdata[WEIGHT_BITS] && (!d_reached || cand < dm_eff[DB-1:0])) begin
          dm_we    = 1'b1;
          dm_wdata = {epoch, dm_eff[DW-2], cand};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      vertex_count <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      epoch        <= 1'b0;
      rl_vld       <= 1'b0;
      fw_vld       <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      fw_vld  <= dm_we;
      fw_v    <= dm_waddr;
      fw_data <= dm_wdata;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AB'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid && !out_valid) begin
            cmd      <= in_ch.payload;
            out_data <= '0;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          ins_second <= 1'b0;
          if (cmd.opcode == gssp_pkg::OP_NONE) begin
            state <= S_OUT;
          end else if (CB'(cmd.vertex_a) >= n_eff || CB'(cmd.vertex_b) >= n_eff ||
                       (VB < gssp_pkg::VID_BITS &&
                        (gssp_pkg::VID_BITS'(va) != cmd.vertex_a ||
                         gssp_pkg::VID_BITS'(vb) != cmd.vertex_b))) begin
            out_data.status <= gssp_pkg::ST_BAD_VERTEX;
            state <= S_OUT;
          end else if (cmd.opcode == gssp_pkg::OP_PATH) begin
            epoch <= ~epoch;
            idx   <= '0;
            state <= S_INIT;
          end else begin
            state <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          if (cmd.opcode == gssp_pkg::OP_INSERT) begin
            if (adj_rdata[WEIGHT_BITS]) begin
              out_data.status <= gssp_pkg::ST_PRESENT;
              state <= S_OUT;
            end else begin
              state <= S_INS;
            end
          end else begin
            if (adj_rdata[WEIGHT_BITS]) begin
              out_data.weight_out <= gssp_pkg::WOUT_BITS'(adj_rdata[WEIGHT_BITS-1:0]);
            end else begin
              out_data.status <= gssp_pkg::ST_NO_EDGE;
            end
            state <= S_OUT;
          end
        end
        S_INS: begin
          ins_second <= 1'b1;
          if (ins_second || va == vb) begin
            state <= S_OUT;
          end
        end
        S_INIT: begin
          // Only the source starts out reached; nothing is settled.
          if (idx == n_eff - CB'(1)) begin
            idx   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            idx <= idx + CB'(1);
          end
        end
        S_SCAN: begin
          // One entry read a cycle; the entry read last cycle is compared.
          if (pend && dm_rdata[DW-1] == epoch && dm_rdata[DW-2] != epoch &&
              (!found || dm_rdata[DB-1:0] < best_d)) begin
            found  <= 1'b1;
            best_u <= pend_v;
            best_d <= dm_rdata[DB-1:0];
          end
          pend   <= idx < n_eff;
          pend_v <= idx[VB-1:0];
          idx    <= idx + CB'(1);
          if (!(idx < n_eff) && !pend) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (!found) begin
            state <= S_FINAL;
          end else begin
            u_v    <= best_u;
            u_d    <= best_d;
            idx    <= '0;
            rl_vld <= 1'b0;
            state  <= S_RELAX;
          end
        end
        S_RELAX: begin
          rl_vld <= idx < n_eff;
          rl_v   <= idx[VB-1:0];
          if (!(idx < n_eff) && !rl_vld) begin
            idx   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            idx <= idx + CB'(1);
          end
        end
        S_FINAL: begin
          rl_vld <= 1'b0;
          state  <= S_FINRD;
        end
        S_FINRD: begin
          if (dm_rdata[DW-1] == epoch) begin
            out_data.distance <= dm_rdata[DB-1:0];
          end else begin
            out_data.status <= gssp_pkg::ST_UNREACHABLE;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state == S_IDLE) && !out_valid;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

endmodule

// ===== sim/tb_graph_store_shortest_path.sv =====
module tb_graph_store_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NV = 64;
  localparam int unsigned CYCLE_LIMIT = 10000000;

  typedef struct {
    bit                                is_cfg;
    logic [gssp_pkg::COUNT_BITS-1:0]   count;
    gssp_pkg::cmd_t                    cmd;
    bit                                typed;
    gssp_pkg::rsp_t                    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gssp_pkg::COUNT_BITS-1:0] cfg_wdata = '0;

  gssp_cmd_if cmd_bus ();
  gssp_rsp_if rsp_bus ();

  graph_store_shortest_path dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (cmd_bus.sink),
    .out_ch    (rsp_bus.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the graph and the vertex count.
  logic [gssp_pkg::WIN_BITS-1:0] edge_weight [NV*NV];
  bit                            edge_on [NV*NV];
  int unsigned                   vertex_count_sh;

  gssp_pkg::rsp_t pending_rsp[$];
  row_t directed_rows[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // Dijkstra over the first n vertices of the shadow graph.
  function automatic bit route_length(input int unsigned n, input int unsigned src,
                                      input int unsigned dst,
                                      output logic [gssp_pkg::DIST_BITS-1:0] d);
    int unsigned dist_v [NV];
    bit settled [NV];
    bit reached [NV];
    int unsigned u, best, cand;
    bit found;
    for (int v = 0; v < NV; v++) begin
      settled[v] = 0;
      reached[v] = 0;
      dist_v[v] = 0;
    end
    reached[src] = 1;
    for (int unsigned r = 0; r < n; r++) begin
      found = 0;
      u = 0;
      best = 0;
      for (int unsigned v = 0; v < n; v++) begin
        if (reached[v] && !settled[v] && (!found || dist_v[v] < best)) begin
          found = 1;
          u = v;
          best = dist_v[v];
        end
      end
      if (!found) break;
      settled[u] = 1;
      for (int unsigned v = 0; v < n; v++) begin
        if (edge_on[u*NV+v]) begin
          cand = best + edge_weight[u*NV+v];
          if (cand > gssp_pkg::DIST_MAX) cand = gssp_pkg::DIST_MAX;
          if (!reached[v] || cand < dist_v[v]) begin
            dist_v[v] = cand;
            reached[v] = 1;
          end
        end
      end
    end
    d = dist_v[dst][gssp_pkg::DIST_BITS-1:0];
    return reached[dst];
  endfunction

  // Works out the response to one command and updates the shadow graph.
  function automatic gssp_pkg::rsp_t apply_command(input gssp_pkg::cmd_t c);
    gssp_pkg::rsp_t r;
    int unsigned n, a, b;
    logic [gssp_pkg::DIST_BITS-1:0] d;
    r = '0;
    n = (vertex_count_sh > NV) ? NV : vertex_count_sh;
    a = c.vertex_a;
    b = c.vertex_b;
    if (gssp_pkg::opcode_t'(c.opcode) == gssp_pkg::OP_NONE) begin
      r.status = gssp_pkg::ST_OK;
    end else if (a >= n || b >= n) begin
      r.status = gssp_pkg::ST_BAD_VERTEX;
    end else begin
      case (gssp_pkg::opcode_t'(c.opcode))
        gssp_pkg::OP_INSERT: begin
          if (edge_on[a*NV+b]) begin
            r.status = gssp_pkg::ST_PRESENT;
          end else begin
            edge_weight[a*NV+b] = c.edge_weight_in;
            edge_weight[b*NV+a] = c.edge_weight_in;
            edge_on[a*NV+b] = 1;
            edge_on[b*NV+a] = 1;
          end
        end
        gssp_pkg::OP_WEIGHT: begin
          if (edge_on[a*NV+b]) r.weight_out = edge_weight[a*NV+b];
          else r.status = gssp_pkg::ST_NO_EDGE;
        end
        default: begin
          if (route_length(n, a, b, d)) r.distance = d;
          else r.status = gssp_pkg::ST_UNREACHABLE;
        end
      endcase
    end
    return r;
  endfunction

  // Drives one command beat and returns at the edge where it is taken.
  task automatic send_command(input gssp_pkg::cmd_t c, input bit typed,
                              input gssp_pkg::rsp_t want);
    gssp_pkg::rsp_t got;
    if ($urandom_range(99) < idle_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.payload <= c;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    got = apply_command(c);
    pending_rsp = {pending_rsp, (typed ? want : got)};
  endtask

  // The bus is lowered at the step of the last accepted beat; once the block drains, the count is written.
  task automatic write_count(input logic [gssp_pkg::COUNT_BITS-1:0] v);
    cmd_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count_sh = v;
  endtask

  function automatic gssp_pkg::cmd_t random_command(input int unsigned n,
                                                    input int unsigned path_pct);
    gssp_pkg::cmd_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) c.opcode = gssp_pkg::OP_NONE;
    else if (pick < 5 + path_pct) c.opcode = gssp_pkg::OP_PATH;
    else if (pick < 35 + path_pct) c.opcode = gssp_pkg::OP_WEIGHT;
    else c.opcode = gssp_pkg::OP_INSERT;
    if (n > 0 && $urandom_range(99) < 90) begin
      c.vertex_a = gssp_pkg::VID_BITS'($urandom_range(n - 1));
      c.vertex_b = gssp_pkg::VID_BITS'($urandom_range(n - 1));
    end else begin
      c.vertex_a = gssp_pkg::VID_BITS'($urandom_range(NV - 1));
      c.vertex_b = gssp_pkg::VID_BITS'($urandom_range(NV - 1));
    end
    if ($urandom_range(3) == 0) c.edge_weight_in = gssp_pkg::WIN_BITS'($urandom_range(15));
    else c.edge_weight_in = gssp_pkg::WIN_BITS'($urandom_range(16'hffff));
    return c;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned items,
                            input int unsigned path_pct, input int unsigned idle,
                            input int unsigned stall);
    int unsigned n;
    write_count(count[gssp_pkg::COUNT_BITS-1:0]);
    idle_pct = idle;
    stall_pct = stall;
    n = (count > NV) ? NV : count;
    for (int i = 0; i < items; i++) send_command(random_command(n, path_pct), 0, '0);
  endtask

  function automatic row_t cmd_row(input gssp_pkg::opcode_t op, input int unsigned a,
                                   input int unsigned b, input int unsigned w,
                                   input bit typed, input gssp_pkg::status_t st,
                                   input int unsigned wout, input int unsigned dist_want);
    row_t r;
    r.is_cfg = 0;
    r.count = '0;
    r.cmd.opcode = op;
    r.cmd.vertex_a = a[gssp_pkg::VID_BITS-1:0];
    r.cmd.vertex_b = b[gssp_pkg::VID_BITS-1:0];
    r.cmd.edge_weight_in = w[gssp_pkg::WIN_BITS-1:0];
    r.typed = typed;
    r.want.status = st;
    r.want.weight_out = wout[gssp_pkg::WOUT_BITS-1:0];
    r.want.distance = dist_want[gssp_pkg::DIST_BITS-1:0];
    return r;
  endfunction

  function automatic row_t cfg_row(input int unsigned count);
    row_t r;
    r = cmd_row(gssp_pkg::OP_NONE, 0, 0, 0, 0, gssp_pkg::ST_OK, 0, 0);
    r.is_cfg = 1;
    r.count = count[gssp_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic add_row(input row_t r);
    directed_rows = {directed_rows, r};
  endtask

  // Response checking against the oldest expectation.
  always @(posedge clk) begin
    gssp_pkg::rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with nothing expected");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.payload.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_bus.payload.status, want.status));
        if (rsp_bus.payload.weight_out !== want.weight_out)
          report_mismatch($sformatf("weight_out %0h, expected %0h",
                                    rsp_bus.payload.weight_out, want.weight_out));
        if (rsp_bus.payload.distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    rsp_bus.payload.distance, want.distance));
      end
    end
  end

  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.payload = '0;
    vertex_count_sh = 0;
    for (int i = 0; i < NV*NV; i++) begin
      edge_on[i] = 0;
      edge_weight[i] = '0;
    end

    // With no vertices in use every real command is out of range.
    add_row(cmd_row(gssp_pkg::OP_INSERT, 0, 0, 5, 1, gssp_pkg::ST_BAD_VERTEX, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_NONE, 63, 63, 16'hffff, 1, gssp_pkg::ST_OK, 0, 0));
    // A count above capacity behaves as the full capacity.
    add_row(cfg_row(100));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 0, 63, 16'hffff, 1, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 63, 0, 1, 1, gssp_pkg::ST_PRESENT, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_WEIGHT, 0, 63, 0, 1, gssp_pkg::ST_OK, 16'hffff, 0));
    add_row(cmd_row(gssp_pkg::OP_WEIGHT, 63, 0, 0, 1, gssp_pkg::ST_OK, 16'hffff, 0));
    add_row(cmd_row(gssp_pkg::OP_WEIGHT, 1, 2, 0, 1, gssp_pkg::ST_NO_EDGE, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 5, 5, 7, 1, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 5, 5, 9, 1, gssp_pkg::ST_PRESENT, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_WEIGHT, 5, 5, 0, 1, gssp_pkg::ST_OK, 7, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 3, 3, 0, 1, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 0, 1, 0, 1, gssp_pkg::ST_UNREACHABLE, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 1, 2, 0, 1, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 0, 1, 16'h1234, 1, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 63, 2, 0, 0, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 2, 63, 0, 0, gssp_pkg::ST_OK, 0, 0));
    add_row(cfg_row(127));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 10, 20, 16'h5555, 0, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 20, 5, 0, 0, gssp_pkg::ST_OK, 0, 0));
    add_row(cfg_row(2));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 2, 0, 3, 1, gssp_pkg::ST_BAD_VERTEX, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_WEIGHT, 0, 63, 0, 1, gssp_pkg::ST_BAD_VERTEX, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_PATH, 1, 0, 0, 0, gssp_pkg::ST_OK, 0, 0));
    add_row(cmd_row(gssp_pkg::OP_INSERT, 1, 1, 16'haaaa, 0, gssp_pkg::ST_OK, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_count(directed_rows[i].count);
      else send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    run_random(8, 25, 25, 0, 0);
    run_random(6, 25, 25, 81, 0);
    run_random(12, 25, 25, 0, 81);
    run_random(3, 20, 30, 37, 37);
    run_random(64, 20, 15, 37, 37);
    run_random(1, 5, 30, 0, 0);

    cmd_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== graph_store_shortest_path.f =====
src/gssp_pkg.sv
src/gssp_if.sv
src/gssp_adj_mem.sv
src/gssp_dist_mem.sv
src/graph_store_shortest_path.sv
sim/tb_graph_store_shortest_path.sv
